/* hw/rtl/qbvs_pkg.sv */
`default_nettype none
package qbvs_pkg;

	localparam int unsigned MAX_QUADS_DEF     = 65536;
	localparam int unsigned TEXTURE_SLOTS_DEF = 32;

	localparam int unsigned SLOT_W = 5;
	localparam int unsigned CS_W   = 20;
	localparam int unsigned Z_W    = 16;
	localparam int unsigned PROD_W = 32 + CS_W;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	localparam logic signed [15:0]     TILE_ONE = 16'sh0100;
	localparam logic signed [CS_W-1:0] CS_ONE   = CS_W'(65536);
	localparam logic signed [CS_W-1:0] CORDIC_X0 = CS_W'(39797);

	typedef struct packed {
		logic               op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic [15:0]        angle;
		logic [31:0]        color_rgba;
		logic [15:0]        texture_id;
		logic signed [15:0] tiling_x;
		logic signed [15:0] tiling_y;
		logic               is_text;
	} req_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [31:0]        vert_color;
		logic [1:0]         corner;
		logic signed [15:0] vert_tiling_x;
		logic signed [15:0] vert_tiling_y;
		logic [SLOT_W-1:0]  tex_slot;
		logic               vert_is_text;
		logic               batch_start;
		logic               last;
	} vert_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic [31:0]        color;
		logic signed [15:0] tiling_x;
		logic signed [15:0] tiling_y;
		logic [SLOT_W-1:0]  slot;
		logic               is_text;
		logic               batch_start;
	} quad_t;

	typedef struct packed {
		logic              done;
		logic              miss;
		logic [SLOT_W-1:0] slot;
	} srch_stat_t;

	function automatic logic [13:0] atan_turn(input logic [3:0] i);
		logic [13:0] v;
		case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			4'd14:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/qbvs_req_if.sv */
`default_nettype none
interface qbvs_req_if;
	logic          valid;
	logic          ready;
	qbvs_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qbvs_vert_if.sv */
`default_nettype none
interface qbvs_vert_if;
	logic           valid;
	logic           ready;
	qbvs_pkg::vert_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qbvs_slot_table.sv */
`default_nettype none
module qbvs_slot_table #(
	parameter int unsigned TEXTURE_SLOTS = qbvs_pkg::TEXTURE_SLOTS_DEF,
	localparam int unsigned CW = $clog2(TEXTURE_SLOTS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [15:0]          tex,
	input  wire logic [CW-1:0]        n,
	output qbvs_pkg::srch_stat_t      stat
);
	import qbvs_pkg::*;

	localparam int unsigned AW = $clog2(TEXTURE_SLOTS);

	logic [15:0]   mem [TEXTURE_SLOTS];
	logic [15:0]   rdata_s1;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] n_q;
	logic [15:0]   tex_q;
	logic          active_q;
	logic          done_q;
	logic          miss_q;
	logic [AW-1:0] slot_q;
	logic          hit;
	logic          more;
	logic          wr_en;

	assign hit   = vld_s1 && (rdata_s1 == tex_q);
	assign more  = rd_q < n_q;
	assign wr_en = active_q && !hit && !more && !vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[n_q[AW-1:0]] <= tex_q;
		end
		rdata_s1 <= mem[rd_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			miss_q   <= 1'b0;
			vld_s1   <= 1'b0;
			rd_q     <= '0;
			n_q      <= '0;
			tex_q    <= '0;
			slot_q   <= '0;
			addr_s1  <= '0;
		end else if (start) begin
			active_q <= (tex != 16'd0);
			done_q   <= (tex == 16'd0);
			miss_q   <= 1'b0;
			vld_s1   <= 1'b0;
			rd_q     <= CW'(1);
			n_q      <= n;
			tex_q    <= tex;
			slot_q   <= '0;
		end else if (active_q) begin
			if (hit) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
				vld_s1   <= 1'b0;
				slot_q   <= addr_s1;
			end else if (more) begin
				vld_s1  <= 1'b1;
				addr_s1 <= rd_q[AW-1:0];
				rd_q    <= rd_q + CW'(1);
			end else begin
				vld_s1 <= 1'b0;
				if (!vld_s1) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
					miss_q   <= 1'b1;
					slot_q   <= n_q[AW-1:0];
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.miss = miss_q;
	assign stat.slot = SLOT_W'(slot_q);

endmodule
`default_nettype wire

/* hw/rtl/qbvs_cordic.sv */
`default_nettype none
module qbvs_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [15:0]                        angle,
	output logic                                    done,
	output logic signed [qbvs_pkg::CS_W-1:0]        cos_o,
	output logic signed [qbvs_pkg::CS_W-1:0]        sin_o
);
	import qbvs_pkg::*;

	logic signed [CS_W-1:0] x_q;
	logic signed [CS_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [3:0]             i_q;
	logic [1:0]             quad_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [CS_W-1:0] xs;
	logic signed [CS_W-1:0] ys;
	logic signed [Z_W-1:0]  at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = signed'({2'b00, atan_turn(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			quad_q <= '0;
		end else if (start) begin
			quad_q <= angle[15:14];
			i_q    <= '0;
			y_q    <= '0;
			z_q    <= signed'({2'b00, angle[13:0]});
			if (angle[13:0] == 14'd0) begin
				x_q    <= CS_ONE;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				x_q    <= CORDIC_X0;
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			i_q <= i_q + 4'd1;
			if (i_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd1: begin
				cos_o = -y_q;
				sin_o = x_q;
			end
			2'd2: begin
				cos_o = -x_q;
				sin_o = -y_q;
			end
			2'd3: begin
				cos_o = y_q;
				sin_o = -x_q;
			end
			default: begin
				cos_o = x_q;
				sin_o = y_q;
			end
		endcase
	end

	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/qbvs_vertex.sv */
`default_nettype none
module qbvs_vertex (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire qbvs_pkg::quad_t              quad,
	input  wire logic signed [qbvs_pkg::CS_W-1:0] cos_i,
	input  wire logic signed [qbvs_pkg::CS_W-1:0] sin_i,
	output logic                              done,
	qbvs_vert_if.source                       vert
);
	import qbvs_pkg::*;

	localparam int unsigned SW = PROD_W + 2;
	localparam logic signed [SW-1:0] RND = SW'(65536);

	quad_t                    quad_q;
	logic signed [CS_W-1:0]   c_q;
	logic signed [CS_W-1:0]   s_q;
	logic signed [PROD_W-1:0] p_q [4];
	logic [1:0]               m_q;
	logic                     mbusy_q;
	logic [1:0]               k_q;
	logic                     ebusy_q;
	logic                     ovld_q;
	logic                     done_q;
	vert_t                    out_q;
	logic signed [31:0]       mul_a;
	logic signed [CS_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [SW-1:0]     ea, eb, ec, ed;
	logic signed [SW-1:0]     sum_x, sum_y;
	logic signed [SW-1:0]     sh_x, sh_y;
	logic                     gx, gy;
	logic                     load;

	assign mul_a = (m_q[0] == 1'b0) ? quad_q.size_x : quad_q.size_y;
	assign mul_b = (m_q == 2'd0 || m_q == 2'd3) ? c_q : s_q;
	assign prod  = mul_a * mul_b;

	assign ea = signed'({{(SW-PROD_W){p_q[0][PROD_W-1]}}, p_q[0]});
	assign eb = signed'({{(SW-PROD_W){p_q[1][PROD_W-1]}}, p_q[1]});
	assign ec = signed'({{(SW-PROD_W){p_q[2][PROD_W-1]}}, p_q[2]});
	assign ed = signed'({{(SW-PROD_W){p_q[3][PROD_W-1]}}, p_q[3]});

	assign gx = (k_q == 2'd1) || (k_q == 2'd2);
	assign gy = k_q[1];

	assign sum_x = (gx ? ea : -ea) - (gy ? eb : -eb) + RND;
	assign sum_y = (gx ? ec : -ec) + (gy ? ed : -ed) + RND;
	assign sh_x  = sum_x >>> 17;
	assign sh_y  = sum_y >>> 17;

	assign load = ebusy_q && (!ovld_q || vert.ready);

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= quad;
			c_q    <= cos_i;
			s_q    <= sin_i;
		end
		if (mbusy_q) begin
			p_q[m_q] <= prod;
		end
		if (load) begin
			out_q.vert_x        <= quad_q.pos_x + sh_x[31:0];
			out_q.vert_y        <= quad_q.pos_y + sh_y[31:0];
			out_q.vert_z        <= quad_q.pos_z;
			out_q.vert_color    <= quad_q.color;
			out_q.corner        <= k_q;
			out_q.vert_tiling_x <= quad_q.tiling_x;
			out_q.vert_tiling_y <= quad_q.tiling_y;
			out_q.tex_slot      <= quad_q.slot;
			out_q.vert_is_text  <= quad_q.is_text;
			out_q.batch_start   <= quad_q.batch_start;
			out_q.last          <= (k_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			ebusy_q <= 1'b0;
			ovld_q  <= 1'b0;
			done_q  <= 1'b0;
			m_q     <= '0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mbusy_q <= 1'b1;
				m_q     <= '0;
			end else if (mbusy_q) begin
				m_q <= m_q + 2'd1;
				if (m_q == 2'd3) begin
					mbusy_q <= 1'b0;
					ebusy_q <= 1'b1;
					k_q     <= '0;
				end
			end
			if (load) begin
				ovld_q <= 1'b1;
				k_q    <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					ebusy_q <= 1'b0;
					done_q  <= 1'b1;
				end
			end else if (vert.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign vert.valid = ovld_q;
	assign vert.data  = out_q;
	assign done       = done_q;

endmodule
`default_nettype wire

/* hw/rtl/quad_batch_vertex_setup.sv */
// Channel   Dir   Transfer   Payload
// req       in    one quad   op, center, size, angle, color, texture, tiling, text flag
// vert      out   one vertex position, color, corner, tiling, slot, flags
//
// A draw runs the 16 CORDIC steps beside the slot scan, which reads one entry per cycle
// over the n slots in use; both are skipped for a flat quad at a quarter-turn angle.
// After setup the four products are formed one at a time, then the four vertices are sent.
// A begin transfer only resets the batch counters and leaves the block idle.
// Reset clears the batch counters; the slot memory is not cleared.
// A stalled vert channel holds the vertex register and stops the quad.
`default_nettype none
module quad_batch_vertex_setup #(
	parameter int unsigned MAX_QUADS     = qbvs_pkg::MAX_QUADS_DEF,
	parameter int unsigned TEXTURE_SLOTS = qbvs_pkg::TEXTURE_SLOTS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qbvs_req_if.sink   req,
	qbvs_vert_if.source vert
);
	import qbvs_pkg::*;

	localparam int unsigned CW = $clog2(TEXTURE_SLOTS + 1);
	localparam int unsigned QW = $clog2(MAX_QUADS + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          slots_q;
	logic [QW-1:0]          quads_q;
	logic                   fresh_q;
	logic                   bstart_q;
	req_t                   req_q;
	logic                   acc;
	logic                   draw;
	logic                   full;
	logic [CW-1:0]          slots_eff;
	srch_stat_t             stat;
	logic                   cs_done;
	logic signed [CS_W-1:0] cos_v;
	logic signed [CS_W-1:0] sin_v;
	logic                   vstart;
	logic                   vdone;
	logic                   textured;
	quad_t                  quad;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign draw      = acc && (req.data.op == OP_DRAW);
	assign full      = (quads_q >= QW'(MAX_QUADS)) ||
	                   ((req.data.texture_id != 16'd0) && (slots_q >= CW'(TEXTURE_SLOTS)));
	assign slots_eff = full ? CW'(1) : slots_q;
	assign vstart    = (state_q == ST_SETUP) && stat.done && cs_done;
	assign textured  = (req_q.texture_id != 16'd0);

	assign quad.pos_x       = req_q.pos_x;
	assign quad.pos_y       = req_q.pos_y;
	assign quad.pos_z       = req_q.pos_z;
	assign quad.size_x      = req_q.size_x;
	assign quad.size_y      = req_q.size_y;
	assign quad.color       = req_q.color_rgba;
	assign quad.tiling_x    = textured ? req_q.tiling_x : TILE_ONE;
	assign quad.tiling_y    = textured ? req_q.tiling_y : TILE_ONE;
	assign quad.slot        = stat.slot;
	assign quad.is_text     = req_q.is_text;
	assign quad.batch_start = bstart_q;

	always_ff @(posedge clk) begin
		if (draw) begin
			req_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			slots_q  <= CW'(1);
			quads_q  <= '0;
			fresh_q  <= 1'b1;
			bstart_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (req.data.op == OP_BEGIN) begin
							slots_q <= CW'(1);
							quads_q <= '0;
							fresh_q <= 1'b1;
						end else begin
							bstart_q <= full || fresh_q;
							fresh_q  <= 1'b0;
							quads_q  <= (full ? '0 : quads_q) + QW'(1);
							slots_q  <= slots_eff;
							state_q  <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					if (vstart) begin
						if (stat.miss) begin
							slots_q <= slots_q + CW'(1);
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (vdone) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	qbvs_slot_table #(
		.TEXTURE_SLOTS(TEXTURE_SLOTS)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (draw),
		.tex    (req.data.texture_id),
		.n      (slots_eff),
		.stat   (stat)
	);

	qbvs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (draw),
		.angle  (req.data.angle),
		.done   (cs_done),
		.cos_o  (cos_v),
		.sin_o  (sin_v)
	);

	qbvs_vertex u_vertex (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vstart),
		.quad   (quad),
		.cos_i  (cos_v),
		.sin_i  (sin_v),
		.done   (vdone),
		.vert   (vert)
	);

	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slots_q >= CW'(1)) && (slots_q <= CW'(TEXTURE_SLOTS)))
		else $error("slot count out of range");

	a_quads_range: assert property (@(posedge clk) disable iff (!arst_n)
		quads_q <= QW'(MAX_QUADS))
		else $error("quad count out of range");

	a_miss_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(vstart && stat.miss) |-> (slots_q < CW'(TEXTURE_SLOTS)))
		else $error("slot allocated beyond table");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vstart |=> (state_q == ST_EMIT) && !req.ready)
		else $error("accept during vertex emission");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
	import qbvs_pkg::*;

	localparam int QUAD_MAX = 65536;
	localparam int SLOT_MAX = 32;
	localparam int WATCHDOG = 20000;
	localparam int LONG_HOLD = 300;

	logic clk;
	logic arst_n;

	qbvs_req_if  req();
	qbvs_vert_if vert();

	quad_batch_vertex_setup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.vert(vert)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor state
	logic [15:0] slot_tex [SLOT_MAX];
	int          slots_used;
	int          quad_count;
	bit          fresh;

	vert_t vert_fifo [$];
	int    errors;
	int    idle_cycles;
	bit    quiet;
	bit    hold_long;

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	task automatic trig(input logic [15:0] ang, output longint c, output longint s);
		longint x, y, z, t;
		logic [13:0] a [16];
		a = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		x = 39797;
		y = 0;
		z = longint'(ang[13:0]);
		if (ang[13:0] == 0) begin
			x = 65536;
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					t = x - asr(y, i);
					y = y + asr(x, i);
					z = z - longint'(a[i]);
				end else begin
					t = x + asr(y, i);
					y = y - asr(x, i);
					z = z + longint'(a[i]);
				end
				x = t;
			end
		end
		case (ang[15:14])
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			2'd3: begin c = y; s = -x; end
			default: begin c = x; s = y; end
		endcase
	endtask

	task automatic predict_quad(input req_t r);
		int slot;
		logic signed [15:0] tx, ty;
		bit st;
		longint c, s, ex, ey, rx, ry;
		vert_t v;
		slot = 0;
		tx = TILE_ONE;
		ty = TILE_ONE;
		if (r.op == OP_BEGIN) begin
			quad_count = 0; slots_used = 1; fresh = 1;
			return;
		end
		if (quad_count >= QUAD_MAX || (r.texture_id != 0 && slots_used >= SLOT_MAX)) begin
			quad_count = 0; slots_used = 1; fresh = 1;
		end
		if (r.texture_id != 0) begin
			for (int i = 1; i < slots_used; i++)
				if (slot == 0 && slot_tex[i] == r.texture_id)
					slot = i;
			if (slot == 0) begin
				slot = slots_used;
				slot_tex[slot] = r.texture_id;
				slots_used++;
			end
			tx = r.tiling_x;
			ty = r.tiling_y;
		end
		st = fresh;
		fresh = 0;
		quad_count++;
		trig(r.angle, c, s);
		for (int k = 0; k < 4; k++) begin
			ex = (k == 0 || k == 3) ? -longint'(r.size_x) : longint'(r.size_x);
			ey = (k < 2) ? -longint'(r.size_y) : longint'(r.size_y);
			rx = asr(ex * c - ey * s + 65536, 17);
			ry = asr(ex * s + ey * c + 65536, 17);
			v.vert_x = 32'(longint'(r.pos_x) + rx);
			v.vert_y = 32'(longint'(r.pos_y) + ry);
			v.vert_z = r.pos_z;
			v.vert_color = r.color_rgba;
			v.corner = 2'(k);
			v.vert_tiling_x = tx;
			v.vert_tiling_y = ty;
			v.tex_slot = 5'(slot);
			v.vert_is_text = r.is_text;
			v.batch_start = st;
			v.last = (k == 3);
			vert_fifo.push_back(v);
		end
	endtask

	function automatic req_t rand_quad(input int tex_range);
		req_t r;
		r.op = OP_DRAW;
		r.pos_x = $urandom;
		r.pos_y = $urandom;
		r.pos_z = $urandom;
		r.size_x = ($urandom_range(0, 3) == 0) ? $urandom : 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
		r.size_y = ($urandom_range(0, 3) == 0) ? $urandom : 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
		r.angle = 16'($urandom);
		r.color_rgba = $urandom;
		r.texture_id = ($urandom_range(0, 4) == 0) ? 16'd0 :
			(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, tex_range)));
		r.tiling_x = 16'($urandom);
		r.tiling_y = 16'($urandom);
		r.is_text = 1'($urandom);
		return r;
	endfunction

	// directed stimulus; expected corner 0 written where obvious
	typedef struct {
		req_t  r;
		bit    chk;
		vert_t v0;
	} row_t;
	row_t rows [$];

	task automatic add_row(input req_t r, input bit chk, input vert_t v0);
		row_t w;
		w.r = r; w.chk = chk; w.v0 = v0;
		rows.push_back(w);
	endtask

	task automatic send(input req_t r);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.data <= r;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_quad(r);
		@(negedge clk);
	endtask

	// receiver
	initial begin
		int gap;
		vert.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				vert.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_long = 0;
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				vert.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				vert.ready <= 1'b1;
			end
		end
	end

	// checker
	always @(posedge clk) begin
		vert_t e, a;
		if (arst_n && vert.valid && vert.ready) begin
			a = vert.data;
			if (vert_fifo.size() == 0) begin
				$display("%0t: unexpected vertex %h", $time, a);
				errors++;
			end else begin
				e = vert_fifo.pop_front();
				if (a !== e) begin
					$display("%0t: vertex mismatch expected %h actual %h", $time, e, a);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (vert.valid && vert.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req_t r;
		vert_t v;
		int n, wait_cnt;
		errors = 0;
		idle_cycles = 0;
		quiet = 0;
		hold_long = 0;
		slots_used = 1;
		quad_count = 0;
		fresh = 1;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// untextured zero quad at origin, angle zero
		r = '0; r.op = OP_DRAW;
		v = '0; v.vert_tiling_x = TILE_ONE; v.vert_tiling_y = TILE_ONE; v.batch_start = 1'b1;
		add_row(r, 1, v);
		r.op = OP_BEGIN; add_row(r, 0, v);
		// size 2 units, angle zero -> corner 0 at (-1,-1) offset
		r = '0; r.op = OP_DRAW; r.size_x = 32'sh20000; r.size_y = 32'sh20000;
		r.texture_id = 16'd7; r.tiling_x = 16'sh7fff; r.tiling_y = -16'sh8000;
		r.color_rgba = 32'hffffffff; r.is_text = 1'b1; r.pos_z = 32'sh7fffffff;
		v = '0; v.vert_x = -32'sh10000; v.vert_y = -32'sh10000; v.vert_z = 32'sh7fffffff;
		v.vert_color = 32'hffffffff; v.vert_tiling_x = 16'sh7fff; v.vert_tiling_y = -16'sh8000;
		v.tex_slot = 5'd1; v.vert_is_text = 1'b1; v.batch_start = 1'b1;
		add_row(r, 1, v);
		// extremes of position and size, all quadrants
		for (int q = 0; q < 4; q++) begin
			r = '0; r.op = OP_DRAW;
			r.pos_x = (q[0]) ? 32'sh7fffffff : -32'sh80000000;
			r.pos_y = (q[1]) ? -32'sh80000000 : 32'sh7fffffff;
			r.size_x = (q[0]) ? -32'sh80000000 : 32'sh7fffffff;
			r.size_y = (q[1]) ? 32'sh7fffffff : -32'sh80000000;
			r.angle = 16'(q * 16384 + q);
			r.texture_id = 16'hffff; r.color_rgba = 32'h0;
			add_row(r, 0, v);
		end
		r.angle = 16'hffff; r.texture_id = 16'd0; add_row(r, 0, v);
		r.angle = 16'h3fff; add_row(r, 0, v);
		// add quads with distinct new textures to part-fill the slot table
		for (int t = 0; t < 33; t++) begin
			r = rand_quad(4);
			r.texture_id = 16'(100 + t);
			if (t > 16) break;
			add_row(r, 0, v);
		end
		foreach (rows[i]) begin
			send(rows[i].r);
			if (rows[i].chk) begin
				n = vert_fifo.size() - 4;
				if (vert_fifo[n] !== rows[i].v0) begin
					$display("%0t: table mismatch expected %h actual %h", $time,
						rows[i].v0, vert_fifo[n]);
					errors++;
				end
			end
		end
		// fill then overflow slots deterministically
		for (int t = 0; t < 40; t++) begin
			r = rand_quad(4);
			r.texture_id = 16'(1000 + t);
			send(r);
		end

		hold_long = 1;
		for (int i = 0; i < 114; i++) begin
			if (i > 90) quiet = 1;
			n = $urandom_range(0, 19);
			if (n == 0) begin
				r = rand_quad(40);
				r.op = OP_BEGIN;
			end else begin
				r = rand_quad((i % 40 < 20) ? 8 : 60);
			end
			send(r);
		end
		req.valid <= 1'b0;

		wait_cnt = 0;
		while (vert_fifo.size() != 0 && wait_cnt < WATCHDOG) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (100) @(negedge clk);
		if (errors == 0 && vert_fifo.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/qbvs_pkg.sv
hw/rtl/qbvs_req_if.sv
hw/rtl/qbvs_vert_if.sv
hw/rtl/qbvs_slot_table.sv
hw/rtl/qbvs_cordic.sv
hw/rtl/qbvs_vertex.sv
hw/rtl/quad_batch_vertex_setup.sv
sim/tb_top.sv
